/* design/kinl_pkg.sv */
package kinl_pkg;

  // Token type carried on a closing beat
  typedef enum logic [2:0] {
    TOK_IDENT    = 3'd0,
    TOK_DEF      = 3'd1,
    TOK_EXTERN   = 3'd2,
    TOK_NUMBER   = 3'd3,
    TOK_OPERATOR = 3'd4,
    TOK_EOF      = 3'd5
  } tok_type_e;

  localparam logic [7:0] BYTE_IGNORED = 8'hFF;
  localparam logic [2:0] KW_DEF_LEN   = 3'd3;
  localparam logic [2:0] KW_EXT_LEN   = 3'd6;
  localparam logic [2:0] POS_MAX      = 3'd7;

  // Result beats caused by one input beat, in output order:
  // slot 0 closes the open token, slot 1 is a token byte,
  // slot 2 closes an operator or reports end of input.
  typedef struct packed {
    logic [2:0] vmask;
    tok_type_e  pre_type;
    logic [7:0] tok_byte;
    tok_type_e  post_type;
  } bundle_t;

  function automatic logic [7:0] kw_def_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h64;  // d
      3'd1:    c = 8'h65;  // e
      3'd2:    c = 8'h66;  // f
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] kw_ext_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h65;  // e
      3'd1:    c = 8'h78;  // x
      3'd2:    c = 8'h74;  // t
      3'd3:    c = 8'h65;  // e
      3'd4:    c = 8'h72;  // r
      3'd5:    c = 8'h6E;  // n
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* design/keyword_identifier_number_lexer_top.sv */
// Byte-stream lexer: splits a character stream into identifiers, keywords
// (def, extern), numbers and one-byte operators.
//
// Slave channel: one input beat per byte. tuser = 1 marks end of input
// (tdata ignored); tuser = 0 carries a data byte in tdata.
// Master channel: each token byte is sent as a beat with tuser = 0, and a
// closing beat with tuser = 1 carries the token type in tdata[10:8].
// tlast marks the last beat caused by one input beat. One input beat
// causes zero to three output beats.
//
// An accepted input beat passes the input register, then the result queue,
// before its first result shows on the output. Throughput: one input
// beat per cycle while the queue has room; the output side sends one beat
// per cycle, so bytes that yield two or three results (token end plus
// operator, token end plus end of input) hold the output side longer.
// The result queue holds FifoDepth input beats' worth of results; when it
// fills because the receiver stalls, s_axis_tready_o drops and no result
// is lost. Whitespace and byte 0xFF yield only the closing beat of an open token.
// Reset (rst_ni low) empties the queue and returns the scanner to idle
// with no token open.
module keyword_identifier_number_lexer_top #(
  parameter int FifoDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_byte
  input  logic        s_axis_tuser_i,   // kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] token_byte, [10:8] token_type, rest zero
  output logic        m_axis_tuser_o,   // out_kind
  output logic        m_axis_tlast_o    // last_of_run
);

  localparam int PtrW = (FifoDepth > 2) ? $clog2(FifoDepth) : 1;
  localparam int CntW = $clog2(FifoDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(FifoDepth - 1);

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_IDENT  = 2'd1,
    MODE_NUMBER = 2'd2
  } mode_e;

  // input register
  logic       s1_valid_q;
  logic       s1_eoi_q;
  logic [7:0] s1_byte_q;

  // scanner state
  mode_e      mode_q, mode_d;
  logic [2:0] pos_q, pos_d;
  logic       def_ok_q, def_ok_d;
  logic       ext_ok_q, ext_ok_d;

  // result queue
  kinl_pkg::bundle_t fifo_q [FifoDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic [2:0]        taken_q;

  kinl_pkg::bundle_t bnd;
  kinl_pkg::tok_type_e close_type;
  logic       in_fire, push, pop, out_fire;
  logic       is_space, is_alpha, is_digit, is_alnum, tok_open;
  kinl_pkg::bundle_t head;
  logic [2:0] rem;
  logic [2:0] cur_oh;
  logic       cur_last;

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------
  // Room check: the beat in s1 moves into the queue next edge, so a new
  // beat is taken only if the queue still has a slot for it afterwards.
  assign s_axis_tready_o = ((CntW + 1)'(cnt_q) + (CntW + 1)'(s1_valid_q))
                           < (CntW + 1)'(FifoDepth);
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_eoi_q  <= s_axis_tuser_i;
      s1_byte_q <= s_axis_tdata_i;
    end
  end

  // ---------------------------------------------------------------------
  // Scanner: one byte per cycle
  // ---------------------------------------------------------------------
  assign is_space = (s1_byte_q == 8'h20) || (s1_byte_q >= 8'h09 && s1_byte_q <= 8'h0D);
  assign is_alpha = (s1_byte_q >= 8'h41 && s1_byte_q <= 8'h5A) ||
                    (s1_byte_q >= 8'h61 && s1_byte_q <= 8'h7A);
  assign is_digit = (s1_byte_q >= 8'h30 && s1_byte_q <= 8'h39);
  assign is_alnum = is_alpha || is_digit;
  assign tok_open = (mode_q == MODE_IDENT) || (mode_q == MODE_NUMBER);

  // type of the token that is open now, should it close
  always_comb begin
    close_type = kinl_pkg::TOK_NUMBER;
    if (mode_q == MODE_IDENT) begin
      if (def_ok_q && pos_q == kinl_pkg::KW_DEF_LEN) begin
        close_type = kinl_pkg::TOK_DEF;
      end else if (ext_ok_q && pos_q == kinl_pkg::KW_EXT_LEN) begin
        close_type = kinl_pkg::TOK_EXTERN;
      end else begin
        close_type = kinl_pkg::TOK_IDENT;
      end
    end
  end

  always_comb begin
    mode_d   = mode_q;
    pos_d    = pos_q;
    def_ok_d = def_ok_q;
    ext_ok_d = ext_ok_q;
    bnd.vmask     = 3'b000;
    bnd.pre_type  = close_type;
    bnd.tok_byte  = s1_byte_q;
    bnd.post_type = kinl_pkg::TOK_OPERATOR;

    if (s1_eoi_q) begin
      bnd.vmask     = {1'b1, 1'b0, tok_open};
      bnd.post_type = kinl_pkg::TOK_EOF;
      mode_d   = MODE_IDLE;
      pos_d    = 3'd0;
      def_ok_d = 1'b0;
      ext_ok_d = 1'b0;
    end else if (tok_open && is_alnum) begin
      // token continues
      bnd.vmask = 3'b010;
      if (mode_q == MODE_IDENT) begin
        def_ok_d = def_ok_q && (pos_q < kinl_pkg::KW_DEF_LEN) &&
                   (kinl_pkg::kw_def_char(pos_q) == s1_byte_q);
        ext_ok_d = ext_ok_q && (pos_q < kinl_pkg::KW_EXT_LEN) &&
                   (kinl_pkg::kw_ext_char(pos_q) == s1_byte_q);
        if (pos_q != kinl_pkg::POS_MAX) begin
          pos_d = pos_q + 3'd1;
        end
      end
    end else begin
      // close whatever is open, then treat the byte as if idle
      bnd.vmask[0] = tok_open;
      mode_d   = MODE_IDLE;
      pos_d    = 3'd0;
      def_ok_d = 1'b0;
      ext_ok_d = 1'b0;
      if (is_space || s1_byte_q == kinl_pkg::BYTE_IGNORED) begin
        bnd.vmask[2:1] = 2'b00;
      end else if (is_alpha) begin
        bnd.vmask[1] = 1'b1;
        mode_d   = MODE_IDENT;
        pos_d    = 3'd1;
        def_ok_d = (kinl_pkg::kw_def_char(3'd0) == s1_byte_q);
        ext_ok_d = (kinl_pkg::kw_ext_char(3'd0) == s1_byte_q);
      end else if (is_digit) begin
        bnd.vmask[1] = 1'b1;
        mode_d = MODE_NUMBER;
      end else begin
        bnd.vmask[2:1] = 2'b11;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      pos_q    <= 3'd0;
      def_ok_q <= 1'b0;
      ext_ok_q <= 1'b0;
    end else if (s1_valid_q) begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      def_ok_q <= def_ok_d;
      ext_ok_q <= ext_ok_d;
    end
  end

  // ---------------------------------------------------------------------
  // Result queue: one bundle per input beat with results, drained one beat at a time
  // ---------------------------------------------------------------------
  assign push = s1_valid_q && (bnd.vmask != 3'b000);

  assign head = fifo_q[rd_ptr_q];
  assign rem  = head.vmask & ~taken_q;

  always_comb begin
    cur_oh   = 3'b100;
    cur_last = 1'b1;
    if (rem[0]) begin
      cur_oh   = 3'b001;
      cur_last = (rem[2:1] == 2'b00);
    end else if (rem[1]) begin
      cur_oh   = 3'b010;
      cur_last = !rem[2];
    end
  end

  assign m_axis_tvalid_o = (cnt_q != '0);
  assign out_fire        = m_axis_tvalid_o && m_axis_tready_i;
  assign pop             = out_fire && cur_last;

  always_comb begin
    m_axis_tdata_o = 16'h0000;
    m_axis_tuser_o = 1'b1;
    if (cur_oh[1]) begin
      m_axis_tdata_o[7:0] = head.tok_byte;
      m_axis_tuser_o      = 1'b0;
    end else if (cur_oh[0]) begin
      m_axis_tdata_o[10:8] = head.pre_type;
    end else begin
      m_axis_tdata_o[10:8] = head.post_type;
    end
  end
  assign m_axis_tlast_o = cur_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      taken_q  <= 3'b000;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
        taken_q  <= 3'b000;
      end else if (out_fire) begin
        taken_q  <= taken_q | cur_oh;
      end
      cnt_q <= cnt_q + CntW'(push) - CntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= bnd;
    end
  end

endmodule

/* design/kinl_checker.sv */
module kinl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [7:0]  s_axis_tdata_i,
  input logic        s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // nothing leaves the block while it is held in reset
  a_rst_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("output valid during reset");

  // a stalled beat keeps its content
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) &&
      $stable(m_axis_tlast_o))
    else $error("output beat changed while stalled");

  // end of input is always the final beat of its run
  a_eoi_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o &&
    m_axis_tdata_o[10:8] == 3'(kinl_pkg::TOK_EOF) |-> m_axis_tlast_o)
    else $error("end-of-input beat without tlast");

  // closing beats carry no byte, byte beats carry no type
  a_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (m_axis_tuser_o ? (m_axis_tdata_o[7:0] == 8'h00)
                      : (m_axis_tdata_o[10:8] == 3'd0)) &&
      m_axis_tdata_o[15:11] == 5'd0)
    else $error("inconsistent output fields");

endmodule

bind keyword_identifier_number_lexer_top kinl_checker u_kinl_checker (.*);
